@@ design/vrc6_sound_generator_assert.svh @@
// Assertion macros used by the sound generator control module.
// The same-cycle form checks the consequent at the edge of the antecedent;
// the next-cycle form checks it at the following edge.
`ifndef VRC6_SOUND_GENERATOR_ASSERT_SVH
`define VRC6_SOUND_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define VRC6_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vrc6 sound generator: assertion failed");
`define VRC6_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vrc6 sound generator: assertion failed");
`else
`define VRC6_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define VRC6_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/vrc6_pkg.sv @@
`default_nettype none

package vrc6_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CPS_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int SAMPLE_W   = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int PER_W      = 14;
    localparam int QUO_W      = 8;
    localparam int ITER_W     = $clog2(QUO_W);
    localparam int SAW_STEPS  = 7;
    localparam int MIX_W      = 16;

    localparam logic [CPS_W-1:0]  CPS_RST  = 24'd2659713;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd19661;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CPS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd2;

    // Register decode.
    localparam logic [ADDR_W-1:0] ADDR_MASK   = 16'hB003;
    localparam logic [ADDR_W-1:0] REG_P0_VOL  = 16'h9000;
    localparam logic [ADDR_W-1:0] REG_P0_LO   = 16'h9001;
    localparam logic [ADDR_W-1:0] REG_P0_HI   = 16'h9002;
    localparam logic [ADDR_W-1:0] REG_P1_VOL  = 16'hA000;
    localparam logic [ADDR_W-1:0] REG_P1_LO   = 16'hA001;
    localparam logic [ADDR_W-1:0] REG_P1_HI   = 16'hA002;
    localparam logic [ADDR_W-1:0] REG_SAW_RATE = 16'hB000;
    localparam logic [ADDR_W-1:0] REG_SAW_LO  = 16'hB001;
    localparam logic [ADDR_W-1:0] REG_SAW_HI  = 16'hB002;
    localparam logic [3:0]        PULSE1_PAGE = 4'hA;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_DIV,
        S_UPD,
        S_MUL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        CH_PULSE0,
        CH_PULSE1,
        CH_SAW
    } t_chan;

    typedef struct packed {
        logic  wr;
        logic  sub;
        logic  div_step;
        logic  upd;
        logic  mix;
        logic  load_out;
        t_chan chan;
    } t_cmd;

    typedef struct packed {
        logic reload;
    } t_sts;

endpackage

`default_nettype wire

@@ design/vrc6_sound_generator.sv @@
// Sound unit with two pulse channels and one sawtooth channel.
// Input channel (i_in_valid / o_in_stall): one transaction carries i_action,
// i_address and i_write_data. A register write (action 0) takes effect at the
// accepting edge and returns nothing; the next transaction can follow at once.
// A sample tick (action 1) steps the three channel accumulators one after
// another and returns one o_sample on the output channel (o_out_valid /
// i_out_stall). Per channel the tick takes a subtract step, and when the
// accumulator has to be reloaded also the divider steps and an update step;
// the reload count comes from an eight-step shared restoring divider. The
// multiply by the i_cfg mix gain and the output load then finish the sample.
// The block holds one tick at a time; o_in_stall is high while it works.
// The output register holds a finished sample while the receiver stalls; a
// following tick is computed meanwhile and waits in its last step until the
// held sample has been taken.
// The user must write configuration (i_cfg_we, i_cfg_index, i_cfg_data)
// only while idle; the block does not enforce it. Reset restores the default
// configuration, clears all channel state at once and leaves the block ready.
`default_nettype none

module vrc6_sound_generator
    import vrc6_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire                        i_action,
    input  wire  [ADDR_W-1:0]          i_address,
    input  wire  [DATA_W-1:0]          i_write_data,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample,
    input  wire                        i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [CPS_W-1:0]           i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    vrc6_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    vrc6_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_sample     (o_sample)
    );

endmodule

`default_nettype wire

@@ design/vrc6_ctrl.sv @@
`default_nettype none
`include "vrc6_sound_generator_assert.svh"

module vrc6_ctrl
    import vrc6_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  wire  i_action,
    output logic o_out_valid,
    input  wire  i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state              r_state, n_state;
    t_chan               r_chan, n_chan;
    logic [ITER_W-1:0]   r_iter, n_iter;
    logic                r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan      <= CH_PULSE0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_iter  <= n_iter;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_chan     = r_chan;
        n_iter     = r_iter;
        o_cmd      = '0;
        o_cmd.chan = r_chan;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.wr = !i_action;
                    if (i_action) begin
                        n_state = S_SUB;
                        n_chan  = CH_PULSE0;
                    end
                end
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                if (i_sts.reload) begin
                    n_state = S_DIV;
                    n_iter  = '0;
                end else begin
                    case (r_chan)
                        CH_PULSE0: n_chan = CH_PULSE1;
                        CH_PULSE1: n_chan = CH_SAW;
                        default:   n_chan = CH_PULSE0;
                    endcase
                    n_state = (r_chan == CH_SAW) ? S_MUL : S_SUB;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_iter         = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(QUO_W - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                case (r_chan)
                    CH_PULSE0: n_chan = CH_PULSE1;
                    CH_PULSE1: n_chan = CH_SAW;
                    default:   n_chan = CH_PULSE0;
                endcase
                n_state = (r_chan == CH_SAW) ? S_MUL : S_SUB;
            end
            S_MUL: begin
                o_cmd.mix = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // The output register is reloaded only once the previous sample has left.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `VRC6_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out, !r_out_valid || !i_out_stall)
    `VRC6_ASSERT_NEXT(a_held_result, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)
    `VRC6_ASSERT_NEXT(a_tick_start, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid && i_action, r_state == S_SUB && r_chan == CH_PULSE0)
    `VRC6_ASSERT_SAME(a_iter_clear, i_clk, i_rst_n, r_state != S_DIV, r_iter == '0)

endmodule

`default_nettype wire

@@ design/vrc6_dpath.sv @@
`default_nettype none

module vrc6_dpath
    import vrc6_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  wire                        i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [CPS_W-1:0]           i_cfg_data,
    input  wire  [ADDR_W-1:0]          i_address,
    input  wire  [DATA_W-1:0]          i_write_data,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    localparam int DEC_W  = 8 + FRAC_BITS;
    localparam int ACC_W  = PER_W + FRAC_BITS;
    localparam int UP     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DOWN   = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam int CPSX_W = CPS_W + UP;
    localparam int PROD_W = (MIX_W - 1) + GAIN_W;

    // Configuration.
    logic [CPS_W-1:0]  r_cps;
    logic              r_swap;
    logic [GAIN_W-1:0] r_gain;

    // Channel state.
    logic [7:0]       r_p_lo   [2];
    logic [3:0]       r_p_hi   [2];
    logic             r_p_en   [2];
    logic [3:0]       r_p_vol  [2];
    logic [4:0]       r_p_duty [2];
    logic [ACC_W-1:0] r_p_acc  [2];
    logic [3:0]       r_p_step [2];
    logic [7:0]       r_s_lo;
    logic [3:0]       r_s_hi;
    logic             r_s_en;
    logic [5:0]       r_s_rate;
    logic [ACC_W-1:0] r_s_acc;
    logic [2:0]       r_s_step;
    logic [7:0]       r_s_level;

    // Reload divider.
    logic [QUO_W-1:0]     r_quo;
    logic [PER_W-1:0]     r_rem;
    logic [PER_W-1:0]     r_dvs;
    logic [FRAC_BITS-1:0] r_low;
    logic [2:0]           r_mod7;

    // Mixer.
    logic [PROD_W-1:0]           r_prod;
    logic                        r_neg;
    logic signed [SAMPLE_W-1:0]  r_sample;

    // Register decode.
    logic [ADDR_W-1:0] addr_sw;
    logic [ADDR_W-1:0] addr_m;
    logic              wr_ch;

    always_comb begin
        addr_sw = i_address;
        if (r_swap) begin
            addr_sw = {i_address[ADDR_W-1:2], i_address[0], i_address[1]};
        end
        addr_m = addr_sw & ADDR_MASK;
        wr_ch  = (addr_m[15:12] == PULSE1_PAGE);
    end

    // Fraction alignment of the sample length.
    logic [CPSX_W-1:0] cps_x;
    logic [DEC_W-1:0]  dec;

    assign cps_x = CPSX_W'(r_cps) << UP;
    assign dec   = cps_x[CPSX_W-1:DOWN];

    // Period and accumulator of the selected channel.
    logic [PER_W-1:0] per;
    logic [12:0]      saw_half;
    logic [ACC_W-1:0] acc_sel;
    logic [ACC_W:0]   diff;
    logic [ACC_W:0]   diff_inv;

    always_comb begin
        saw_half = {1'b0, r_s_hi, r_s_lo} + 13'd1;
        case (i_cmd.chan)
            CH_PULSE0: begin
                per     = PER_W'({r_p_hi[0], r_p_lo[0]}) + PER_W'(1);
                acc_sel = r_p_acc[0];
            end
            CH_PULSE1: begin
                per     = PER_W'({r_p_hi[1], r_p_lo[1]}) + PER_W'(1);
                acc_sel = r_p_acc[1];
            end
            default: begin
                per     = {saw_half, 1'b0};
                acc_sel = r_s_acc;
            end
        endcase
        diff     = {1'b0, acc_sel} - (ACC_W + 1)'(dec);
        // When the difference is negative its inverse is the deficit minus one.
        diff_inv = ~diff;
    end

    assign o_sts.reload = diff[ACC_W];

    // One restoring division step on the integer part of the deficit minus one.
    logic [PER_W:0]   trial;
    logic             q_bit;
    logic [PER_W-1:0] rem_n;
    logic [3:0]       mod_x;
    logic [2:0]       mod7_n;

    always_comb begin
        trial  = {r_rem, r_quo[QUO_W-1]};
        q_bit  = (trial >= {1'b0, r_dvs});
        rem_n  = q_bit ? PER_W'(trial - {1'b0, r_dvs}) : trial[PER_W-1:0];
        mod_x  = {r_mod7, q_bit};
        mod7_n = (mod_x >= 4'(SAW_STEPS)) ? 3'(mod_x - 4'(SAW_STEPS)) : mod_x[2:0];
    end

    // Reload bookkeeping: n = quotient + 1 reloads.
    logic [ACC_W-1:0] acc_new;
    logic [8:0]       n_rl;
    logic [2:0]       n_mod7;
    logic             saw_wrap;
    logic [3:0]       wrap_sum;
    logic [2:0]       wrap_step;

    always_comb begin
        acc_new  = {r_dvs, {FRAC_BITS{1'b0}}} - ACC_W'(1) - {r_rem, r_low};
        n_rl     = {1'b0, r_quo} + 9'd1;
        n_mod7   = (r_mod7 == 3'(SAW_STEPS - 1)) ? 3'd0 : r_mod7 + 3'd1;
        saw_wrap = ({6'b0, r_s_step} + n_rl) >= 9'(SAW_STEPS);
        wrap_sum = {1'b0, r_s_step} + {1'b0, n_mod7};
        wrap_step = (wrap_sum >= 4'(SAW_STEPS)) ? 3'(wrap_sum - 4'(SAW_STEPS))
                                                : wrap_sum[2:0];
    end

    // Channel outputs and mix.
    logic signed [MIX_W-1:0] p_out [2];
    logic signed [MIX_W-1:0] s_out;
    logic signed [MIX_W-1:0] mix_sum;
    logic [MIX_W-2:0]        mix_mag;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            p_out[c] = '0;
            if (r_p_en[c]) begin
                if ({1'b0, r_p_step[c]} < r_p_duty[c]) begin
                    p_out[c] = -$signed(MIX_W'({r_p_vol[c], 8'b0}));
                end else begin
                    p_out[c] = $signed(MIX_W'({r_p_vol[c], 8'b0}));
                end
            end
        end
        s_out   = r_s_en ? $signed(MIX_W'({r_s_level[7:3], 9'b0})) : '0;
        mix_sum = p_out[0] + p_out[1] + s_out;
        mix_mag = mix_sum[MIX_W-1] ? (MIX_W-1)'(-mix_sum) : mix_sum[MIX_W-2:0];
    end

    // Saturation to the sample range.
    logic [MIX_W-2:0]           scaled;
    logic signed [SAMPLE_W-1:0] sat;

    always_comb begin
        scaled = r_prod[PROD_W-1:GAIN_W];
        if (r_neg) begin
            if (scaled > (MIX_W-1)'(2 ** (SAMPLE_W - 1))) begin
                sat = $signed(SAMPLE_W'(2 ** (SAMPLE_W - 1)));
            end else begin
                sat = $signed(SAMPLE_W'(-scaled));
            end
        end else begin
            if (scaled > (MIX_W-1)'(2 ** (SAMPLE_W - 1) - 1)) begin
                sat = $signed(SAMPLE_W'(2 ** (SAMPLE_W - 1) - 1));
            end else begin
                sat = $signed(scaled[SAMPLE_W-1:0]);
            end
        end
    end

    // Configuration and channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cps     <= CPS_RST;
            r_swap    <= 1'b0;
            r_gain    <= GAIN_RST;
            for (int c = 0; c < 2; c++) begin
                r_p_lo[c]   <= '0;
                r_p_hi[c]   <= '0;
                r_p_en[c]   <= 1'b0;
                r_p_vol[c]  <= '0;
                r_p_duty[c] <= 5'd1;
                r_p_acc[c]  <= '0;
                r_p_step[c] <= '0;
            end
            r_s_lo    <= '0;
            r_s_hi    <= '0;
            r_s_en    <= 1'b0;
            r_s_rate  <= '0;
            r_s_acc   <= '0;
            r_s_step  <= '0;
            r_s_level <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CPS:  r_cps  <= i_cfg_data;
                    CFG_SWAP: r_swap <= i_cfg_data[0];
                    CFG_GAIN: r_gain <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.wr) begin
                case (addr_m)
                    REG_P0_VOL, REG_P1_VOL: begin
                        r_p_vol[wr_ch]  <= i_write_data[3:0];
                        r_p_duty[wr_ch] <= {1'b0, i_write_data[7:4]} + 5'd1;
                    end
                    REG_P0_LO, REG_P1_LO: begin
                        r_p_lo[wr_ch] <= i_write_data;
                    end
                    REG_P0_HI, REG_P1_HI: begin
                        r_p_hi[wr_ch] <= i_write_data[3:0];
                        r_p_en[wr_ch] <= i_write_data[7];
                    end
                    REG_SAW_RATE: r_s_rate <= i_write_data[5:0];
                    REG_SAW_LO:   r_s_lo   <= i_write_data;
                    REG_SAW_HI: begin
                        r_s_hi <= i_write_data[3:0];
                        r_s_en <= i_write_data[7];
                    end
                    default: ;
                endcase
            end
            // Without a reload the accumulator just takes the difference.
            if (i_cmd.sub && !diff[ACC_W]) begin
                case (i_cmd.chan)
                    CH_PULSE0: r_p_acc[0] <= diff[ACC_W-1:0];
                    CH_PULSE1: r_p_acc[1] <= diff[ACC_W-1:0];
                    default:   r_s_acc    <= diff[ACC_W-1:0];
                endcase
            end
            if (i_cmd.upd) begin
                case (i_cmd.chan)
                    CH_PULSE0: begin
                        r_p_acc[0]  <= acc_new;
                        r_p_step[0] <= r_p_step[0] + r_quo[3:0] + 4'd1;
                    end
                    CH_PULSE1: begin
                        r_p_acc[1]  <= acc_new;
                        r_p_step[1] <= r_p_step[1] + r_quo[3:0] + 4'd1;
                    end
                    default: begin
                        r_s_acc <= acc_new;
                        // Once the step wraps, the level restarts from zero.
                        if (saw_wrap) begin
                            r_s_step  <= wrap_step;
                            r_s_level <= 8'(r_s_rate) * 8'(wrap_step);
                        end else begin
                            r_s_step  <= r_s_step + n_rl[2:0];
                            r_s_level <= r_s_level + 8'(r_s_rate) * 8'(n_rl[2:0]);
                        end
                    end
                endcase
            end
        end
    end

    // Divider and mixer datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sub) begin
            r_quo  <= diff_inv[FRAC_BITS+QUO_W-1:FRAC_BITS];
            r_low  <= diff_inv[FRAC_BITS-1:0];
            r_rem  <= '0;
            r_mod7 <= '0;
            r_dvs  <= per;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[QUO_W-2:0], q_bit};
            r_rem  <= rem_n;
            r_mod7 <= mod7_n;
        end
        if (i_cmd.mix) begin
            r_prod <= mix_mag * r_gain;
            r_neg  <= mix_sum[MIX_W-1];
        end
        if (i_cmd.load_out) begin
            r_sample <= sat;
        end
    end

    assign o_sample = r_sample;

endmodule

`default_nettype wire

@@ tb/tb_vrc6_sound_generator.sv @@
`default_nettype none

module tb_vrc6_sound_generator;
    import vrc6_pkg::*;

    localparam logic                 ACT_WRITE  = 1'b0;
    localparam logic                 ACT_TICK   = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int     FRAC           = FRAC_BITS_DEF;
    localparam longint SMP_MAX        = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SMP_MIN        = -(64'sd1 <<< (SAMPLE_W - 1));
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     RANDOM_ITEMS   = 930;
    localparam int     PHASE_ITEMS    = 120;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TICK,
        ROW_CFG
    } t_row_kind;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [ADDR_W-1:0]     adr;
        logic [CPS_W-1:0]      val;
        logic                  typed;
        logic [SAMPLE_W-1:0]   smp;
    } t_row;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 i_action     = ACT_WRITE;
    logic [ADDR_W-1:0]    i_address    = '0;
    logic [DATA_W-1:0]    i_write_data = '0;
    logic                 i_out_stall  = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = CFG_CPS;
    logic [CPS_W-1:0]     i_cfg_data   = '0;
    wire                  o_in_stall;
    wire                  o_out_valid;
    wire [SAMPLE_W-1:0]   o_sample;

    vrc6_sound_generator i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample     (o_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Predictor copy of configuration and channel state.
    logic [CPS_W-1:0]  cps_cfg;
    logic              swap_cfg;
    logic [GAIN_W-1:0] gain_cfg;
    logic [7:0]        sq_per_lo[2];
    logic [3:0]        sq_per_hi[2];
    logic              sq_on[2];
    logic [3:0]        sq_vol[2];
    logic [4:0]        sq_duty[2];
    longint            sq_phase[2];
    logic [3:0]        sq_seq[2];
    logic [7:0]        ramp_per_lo;
    logic [3:0]        ramp_per_hi;
    logic              ramp_on;
    logic [5:0]        ramp_rate;
    longint            ramp_phase;
    logic [2:0]        ramp_seq;
    logic [7:0]        ramp_level;

    logic [SAMPLE_W-1:0] sample_q[$];
    logic [SAMPLE_W-1:0] want_sample;
    t_row                stim_rows[$];
    int                  mismatches  = 0;
    int                  idle_cycles = 0;
    int                  burst_left  = 0;
    int                  items_sent  = 0;
    bit                  hold_req    = 1'b0;

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                   input logic [SAMPLE_W-1:0] want);
        mismatches++;
        $display("ERROR: %s, got %0d, expected %0d", what, $signed(got), $signed(want));
    endtask

    task automatic clear_sound_state();
        cps_cfg     = CPS_RST;
        swap_cfg    = 1'b0;
        gain_cfg    = GAIN_RST;
        for (int ch = 0; ch < 2; ch++) begin
            sq_per_lo[ch] = '0;
            sq_per_hi[ch] = '0;
            sq_on[ch]     = 1'b0;
            sq_vol[ch]    = '0;
            sq_duty[ch]   = 5'd1;
            sq_phase[ch]  = 0;
            sq_seq[ch]    = '0;
        end
        ramp_per_lo = '0;
        ramp_per_hi = '0;
        ramp_on     = 1'b0;
        ramp_rate   = '0;
        ramp_phase  = 0;
        ramp_seq    = '0;
        ramp_level  = '0;
    endtask

    // Consume one sample period of chip cycles, then reload by whole periods
    // until the phase is non-negative again.
    task automatic step_phase(input longint phase_in, input longint period_q,
                              output longint phase_out, output longint reloads);
        longint dec;
        longint a;
        dec = (FRAC >= 16) ? (longint'(cps_cfg) << (FRAC - 16))
                           : (longint'(cps_cfg) >> (16 - FRAC));
        a = phase_in - dec;
        reloads = 0;
        if (a < 0) begin
            reloads = (-a + period_q - 1) / period_q;
            a = a + reloads * period_q;
        end
        phase_out = a;
    endtask

    task automatic predict_tick(output logic [SAMPLE_W-1:0] smp);
        longint sum;
        longint mag;
        longint nrel;
        longint per;
        longint nxt;
        sum = 0;
        for (int ch = 0; ch < 2; ch++) begin
            per = longint'({sq_per_hi[ch], sq_per_lo[ch]}) + 1;
            step_phase(sq_phase[ch], per << FRAC, nxt, nrel);
            sq_phase[ch] = nxt;
            sq_seq[ch] = sq_seq[ch] + nrel[3:0];
            if (sq_on[ch]) begin
                if ({1'b0, sq_seq[ch]} < sq_duty[ch])
                    sum = sum - (longint'(sq_vol[ch]) << 8);
                else
                    sum = sum + (longint'(sq_vol[ch]) << 8);
            end
        end
        per = (longint'({ramp_per_hi, ramp_per_lo}) + 1) * 2;
        step_phase(ramp_phase, per << FRAC, nxt, nrel);
        ramp_phase = nxt;
        for (longint k = 0; k < nrel; k++) begin
            ramp_level = ramp_level + ramp_rate;
            ramp_seq = ramp_seq + 3'd1;
            if (ramp_seq == SAW_STEPS) begin
                ramp_seq   = '0;
                ramp_level = '0;
            end
        end
        if (ramp_on)
            sum = sum + (longint'(ramp_level[7:3]) << 9);
        // Scale the magnitude so that the result truncates toward zero.
        mag = (sum < 0) ? -sum : sum;
        mag = (mag * longint'(gain_cfg)) >> 16;
        if (sum < 0)
            mag = -mag;
        if (mag > SMP_MAX)
            mag = SMP_MAX;
        if (mag < SMP_MIN)
            mag = SMP_MIN;
        smp = mag[SAMPLE_W-1:0];
    endtask

    task automatic predict_write(input logic [ADDR_W-1:0] adr, input logic [DATA_W-1:0] dat);
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] m;
        int                ch;
        a = adr;
        if (swap_cfg)
            a = {adr[ADDR_W-1:2], adr[0], adr[1]};
        m  = a & ADDR_MASK;
        ch = (m[15:12] == PULSE1_PAGE) ? 1 : 0;
        case (m)
            REG_P0_VOL, REG_P1_VOL: begin
                sq_vol[ch]  = dat[3:0];
                sq_duty[ch] = {1'b0, dat[7:4]} + 5'd1;
            end
            REG_P0_LO, REG_P1_LO: begin
                sq_per_lo[ch] = dat;
            end
            REG_P0_HI, REG_P1_HI: begin
                sq_per_hi[ch] = dat[3:0];
                sq_on[ch]     = dat[7];
            end
            REG_SAW_RATE: ramp_rate = dat[5:0];
            REG_SAW_LO:   ramp_per_lo = dat;
            REG_SAW_HI: begin
                ramp_per_hi = dat[3:0];
                ramp_on     = dat[7];
            end
            default: ;
        endcase
    endtask

    function automatic void add_write(input logic [ADDR_W-1:0] adr, input logic [DATA_W-1:0] dat);
        t_row row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.adr   = adr;
        row.val   = CPS_W'(dat);
        stim_rows.push_back(row);
    endfunction

    function automatic void add_tick(input logic typed, input logic [SAMPLE_W-1:0] smp);
        t_row row;
        row       = '0;
        row.kind  = ROW_TICK;
        row.typed = typed;
        row.smp   = smp;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CPS_W-1:0] val);
        t_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.val  = val;
        stim_rows.push_back(row);
    endfunction

    // Offer one transaction and hold it until accepted. A tick books its sample.
    task automatic send_item(input logic act, input logic [ADDR_W-1:0] adr,
                             input logic [DATA_W-1:0] dat, input logic typed,
                             input logic [SAMPLE_W-1:0] typed_smp);
        logic [SAMPLE_W-1:0] smp;
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_address    <= adr;
        i_write_data <= dat;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (act == ACT_TICK) begin
            predict_tick(smp);
            sample_q.push_back(typed ? typed_smp : smp);
        end else begin
            predict_write(adr, dat);
        end
    endtask

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    endtask

    // Configuration only changes with nothing in flight.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CPS_W-1:0] val);
        i_in_valid <= 1'b0;
        while (sample_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CPS:  cps_cfg  = val;
            CFG_SWAP: swap_cfg = val[0];
            CFG_GAIN: gain_cfg = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_random();
        int                pick;
        logic [ADDR_W-1:0] adr;
        logic [ADDR_W-1:0] base;
        logic [DATA_W-1:0] dat;
        pick = $urandom_range(0, 99);
        adr  = ADDR_W'($urandom);
        dat  = DATA_W'($urandom);
        if (pick < 45) begin
            send_item(ACT_TICK, adr, dat, 1'b0, '0);
            items_sent++;
        end else if (pick < 92) begin
            case ($urandom_range(0, 8))
                0:       base = REG_P0_VOL;
                1:       base = REG_P0_LO;
                2:       base = REG_P0_HI;
                3:       base = REG_P1_VOL;
                4:       base = REG_P1_LO;
                5:       base = REG_P1_HI;
                6:       base = REG_SAW_RATE;
                7:       base = REG_SAW_LO;
                default: base = REG_SAW_HI;
            endcase
            // Undecoded bits are random, so mirrored addresses are exercised.
            adr = base | (adr & ~ADDR_MASK);
            if (base == REG_P0_HI || base == REG_P1_HI || base == REG_SAW_HI) begin
                if ($urandom_range(0, 2) != 0)
                    dat[3:0] = '0;
                if ($urandom_range(0, 3) != 0)
                    dat[7] = 1'b1;
            end
            if (swap_cfg)
                adr = {adr[ADDR_W-1:2], adr[0], adr[1]};
            send_item(ACT_WRITE, adr, dat, 1'b0, '0);
            items_sent++;
        end else begin
            send_item(ACT_WRITE, adr, dat, 1'b0, '0);
            items_sent++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sample_q.size() == 0) begin
                report_mismatch("sample with no tick pending", o_sample, '0);
            end else begin
                want_sample = sample_q.pop_front();
                if (o_sample !== want_sample)
                    report_mismatch("sample", o_sample, want_sample);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : out_stall_gen
        t_stall_mode mode;
        int          mode_cnt;
        int          hold_cnt;
        mode     = STALL_NONE;
        mode_cnt = 0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (mode_cnt == 0) begin
                mode     = t_stall_mode'($urandom_range(0, 2));
                mode_cnt = $urandom_range(16, 128);
            end else begin
                mode_cnt--;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_NONE: i_out_stall <= 1'b0;
                    STALL_HALF: i_out_stall <= ($urandom_range(0, 1) == 1);
                    default:    i_out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int phase;
        clear_sound_state();

        add_tick(1'b1, '0);             // nothing is enabled out of reset
        add_write(REG_P0_VOL, 8'hFF);
        add_write(REG_P0_LO, 8'h00);
        add_write(REG_P0_HI, 8'h80);
        add_write(REG_P1_VOL, 8'h0F);
        add_write(REG_P1_LO, 8'hFF);
        add_write(REG_P1_HI, 8'h8F);
        add_write(REG_SAW_RATE, 8'h3F);
        add_write(REG_SAW_LO, 8'h00);
        add_write(REG_SAW_HI, 8'h80);
        add_tick(1'b0, '0);
        add_tick(1'b0, '0);
        add_write(16'hD000, 8'h7A);     // mirror of pulse 0 volume
        add_write(16'h8000, 8'hFF);     // decodes to nothing
        add_write(16'hB003, 8'hFF);     // decodes to nothing
        add_tick(1'b0, '0);
        add_cfg(CFG_SWAP, 24'd1);
        add_write(REG_P0_HI, 8'h10);    // lands on period low with the lines swapped
        add_write(REG_SAW_LO, 8'h85);   // lands on saw period high and enable
        add_tick(1'b0, '0);
        add_cfg(CFG_GAIN, 24'hFFFF);
        add_tick(1'b0, '0);
        add_cfg(CFG_GAIN, 24'd0);
        add_tick(1'b1, '0);
        add_cfg(CFG_GAIN, CPS_W'(GAIN_RST));
        add_cfg(CFG_CPS, 24'd0);
        add_tick(1'b0, '0);
        add_cfg(CFG_CPS, 24'hFFFFFF);
        add_tick(1'b0, '0);
        add_cfg(CFG_UNUSED, 24'hA5C3FF);
        add_cfg(CFG_CPS, 24'h010000);
        add_cfg(CFG_SWAP, 24'd0);
        add_tick(1'b0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            case (stim_rows[r].kind)
                ROW_CFG: begin
                    cfg_write(stim_rows[r].idx, stim_rows[r].val);
                end
                ROW_TICK: begin
                    send_item(ACT_TICK, ADDR_W'($urandom), DATA_W'($urandom),
                              stim_rows[r].typed, stim_rows[r].smp);
                    pace_sender();
                end
                default: begin
                    send_item(ACT_WRITE, stim_rows[r].adr, stim_rows[r].val[DATA_W-1:0],
                              1'b0, '0);
                    pace_sender();
                end
            endcase
        end

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       cfg_write(CFG_CPS, 24'h010000);
                1:       cfg_write(CFG_CPS, 24'hFFFFFF);
                2:       cfg_write(CFG_CPS, CPS_W'($urandom_range(0, 24'hFFFFFF)));
                default: cfg_write(CFG_CPS, CPS_W'($urandom_range(24'h010000, 24'h400000)));
            endcase
            cfg_write(CFG_SWAP, CPS_W'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0:       cfg_write(CFG_GAIN, 24'd0);
                1:       cfg_write(CFG_GAIN, 24'hFFFF);
                2:       cfg_write(CFG_GAIN, CPS_W'(GAIN_RST));
                default: cfg_write(CFG_GAIN, CPS_W'($urandom_range(0, 16'hFFFF)));
            endcase
            // Once, block the output for a long time while transactions keep
            // coming back to back, so that the input backs up.
            if (phase == 2) begin
                hold_req = 1'b1;
                repeat (60) send_random();
            end
            for (int j = 0; j < PHASE_ITEMS && items_sent < RANDOM_ITEMS; j++) begin
                send_random();
                pace_sender();
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        while (sample_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ vrc6_sound_generator.f @@
+incdir+design
design/vrc6_pkg.sv
design/vrc6_ctrl.sv
design/vrc6_dpath.sv
design/vrc6_sound_generator.sv
tb/tb_vrc6_sound_generator.sv
